// File: hw/rtl/ipid_pkg.sv
// Shared types, constants and helpers for the integer PID step unit.
package ipid_pkg;

  localparam int ERR_W   = 16;
  localparam int STEP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int INT_W   = 32;
  localparam int DRV_W   = 32;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = INT_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int CNT_W   = $clog2(STEP_W);
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STEP_W - 1);

  localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sh0000_0000_8000_0000);

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT_MUL,
    S_INT_ADD,
    S_DIV,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC,
    S_OUT
  } ipid_state_t;

  typedef enum logic [1:0] {
    MSEL_ERR_STEP,
    MSEL_PROP,
    MSEL_INTEG,
    MSEL_DERIV
  } ipid_msel_t;

  typedef struct packed {
    logic       load;
    logic       int_upd;
    logic       div_step;
    ipid_msel_t mul_sel;
    logic       prod_en;
    logic       acc_clr;
    logic       acc_en;
    logic       out_load;
  } ipid_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } ipid_sts_t;

  function automatic logic signed [DRV_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DRV_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DRV_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DRV_W-1:0];
    end else begin
      r = v[DRV_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ipid_ctrl.sv
// Sequencing state machine for the PID step unit.
module ipid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipid_pkg::ipid_sts_t sts,
  output ipid_pkg::ipid_cmd_t cmd
);
  import ipid_pkg::*;

  ipid_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_INT_MUL;
      S_INT_MUL: state_nxt = S_INT_ADD;
      S_INT_ADD: state_nxt = S_DIV;
      S_DIV:     if (sts.div_last) state_nxt = S_MUL_P;
      S_MUL_P:   state_nxt = S_MUL_I;
      S_MUL_I:   state_nxt = S_MUL_D;
      S_MUL_D:   state_nxt = S_ACC;
      S_ACC:     state_nxt = S_OUT;
      S_OUT:     if (sts.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INT_MUL: begin
        cmd.mul_sel = MSEL_ERR_STEP;
        cmd.prod_en = 1'b1;
      end
      S_INT_ADD: cmd.int_upd  = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_MUL_P: begin
        cmd.mul_sel = MSEL_PROP;
        cmd.prod_en = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      S_MUL_I: begin
        cmd.mul_sel = MSEL_INTEG;
        cmd.prod_en = 1'b1;
        cmd.acc_en  = 1'b1;
      end
      S_MUL_D: begin
        cmd.mul_sel = MSEL_DERIV;
        cmd.prod_en = 1'b1;
        cmd.acc_en  = 1'b1;
      end
      S_ACC:   cmd.acc_en   = 1'b1;
      S_OUT:   cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register occupied");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_INT_MUL))
    else $error("accepted item did not start the sequence");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_MUL_P))
    else $error("divider finished but sequence did not advance");

endmodule

// File: hw/rtl/ipid_dp.sv
// Datapath: shared multiplier, accumulator, restoring divider, state and output register.
module ipid_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  ipid_pkg::ipid_cmd_t                      cmd,
  output ipid_pkg::ipid_sts_t                      sts,
  input  logic signed [ipid_pkg::ERR_W-1:0]        in_error_in,
  input  logic        [ipid_pkg::STEP_W-1:0]       in_time_step,
  input  logic signed [ipid_pkg::GAIN_W-1:0]       prop_gain,
  input  logic signed [ipid_pkg::GAIN_W-1:0]       integ_gain,
  input  logic signed [ipid_pkg::GAIN_W-1:0]       deriv_gain,
  output logic signed [ipid_pkg::DRV_W-1:0]        out_drive_out,
  output logic                                     out_step_zero_flag,
  output logic                                     out_valid,
  input  logic                                     out_ready
);
  import ipid_pkg::*;

  logic signed [ERR_W-1:0]   err_r;
  logic        [STEP_W-1:0]  step_r;
  logic                      zero_r;
  logic                      neg_r;
  logic signed [ERR_W-1:0]   last_error_r;
  logic signed [INT_W-1:0]   integral_r;
  logic        [STEP_W-1:0]  dvd_r;
  logic        [STEP_W:0]    rem_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [DRV_W-1:0]   drive_r;
  logic                      flag_r;
  logic                      out_valid_r;

  logic signed [DIFF_W-1:0]  diff;
  logic        [DIFF_W-1:0]  diff_mag;
  logic        [STEP_W:0]    trial;
  logic                      qbit;
  logic signed [DIFF_W-1:0]  deriv;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  assign diff     = DIFF_W'(in_error_in) - DIFF_W'(last_error_r);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r[STEP_W-1:0], dvd_r[STEP_W-1]};
  assign qbit  = (trial >= {1'b0, step_r});

  always_comb begin
    if (zero_r) begin
      deriv = '0;
    end else if (neg_r) begin
      deriv = -$signed({1'b0, dvd_r});
    end else begin
      deriv = $signed({1'b0, dvd_r});
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MSEL_ERR_STEP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = $signed({{(MUL_B_W-STEP_W){1'b0}}, step_r});
      end
      MSEL_PROP: begin
        mul_a = MUL_A_W'(prop_gain);
        mul_b = MUL_B_W'(err_r);
      end
      MSEL_INTEG: begin
        mul_a = MUL_A_W'(integ_gain);
        mul_b = MUL_B_W'(integral_r);
      end
      default: begin
        mul_a = MUL_A_W'(deriv_gain);
        mul_b = MUL_B_W'(deriv);
      end
    endcase
  end

  // Control-visible state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      integral_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_error_r <= in_error_in;
      end
      if (cmd.int_upd) begin
        integral_r <= sat32(PROD_W'(integral_r) + prod_r);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_r  <= in_error_in;
      step_r <= in_time_step;
      zero_r <= (in_time_step == '0);
      neg_r  <= diff[DIFF_W-1];
      dvd_r  <= diff_mag[STEP_W-1:0];
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? (trial - {1'b0, step_r}) : trial;
      dvd_r <= {dvd_r[STEP_W-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.prod_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.out_load) begin
      drive_r <= sat32(acc_r);
      flag_r  <= zero_r;
    end
  end

  assign sts.div_last = (cnt_r == DIV_LAST);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_drive_out      = drive_r;
  assign out_step_zero_flag = flag_r;
  assign out_valid          = out_valid_r;

  a_valid_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("output register not marked valid after load");

  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (flag_r == $past(zero_r)))
    else $error("step-zero flag does not follow the captured step");

  a_int_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.int_upd && zero_r) |=> $stable(integral_r))
    else $error("integral moved on a zero step");

endmodule

// File: hw/rtl/integer_pid_step_unit.sv
// Top level of the integer PID step unit: register file, controller and datapath.
//
//  Channel  Direction  Handshake               Payload
//  in_      input      in_valid / in_ready     in_error_in[15:0] s, in_time_step[15:0] u
//  out_     output     out_valid / out_ready   out_drive_out[31:0] s, out_step_zero_flag
//  cfg      input      psel/penable/pwrite     paddr[3:0], pwdata[31:0], prdata[31:0]
//
//  Sequence per item, one item at a time: accept, integral multiply and add, a
//  16-step restoring divide for the slope, three products through the one shared
//  17x33 multiplier plus accumulate, load.
//  Reset clears the gains, the integral and the last error; no clearing pass.
//  A stalled result holds in the output register; the next item is still taken
//  and runs until its own result load, where it waits for the register to free.
module integer_pid_step_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ipid_pkg::ERR_W-1:0]    in_error_in,
  input  logic        [ipid_pkg::STEP_W-1:0]   in_time_step,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ipid_pkg::DRV_W-1:0]    out_drive_out,
  output logic                                 out_step_zero_flag,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [ipid_pkg::ADDR_W-1:0]   paddr,
  input  logic        [ipid_pkg::DATA_W-1:0]   pwdata,
  output logic        [ipid_pkg::DATA_W-1:0]   prdata,
  output logic                                 pready
);
  import ipid_pkg::*;

  logic signed [GAIN_W-1:0] prop_gain_r;
  logic signed [GAIN_W-1:0] integ_gain_r;
  logic signed [GAIN_W-1:0] deriv_gain_r;
  logic                     cfg_wr;
  logic [1:0]               cfg_idx;
  ipid_cmd_t                cmd;
  ipid_sts_t                sts;

  // Zero-wait port: every access completes in its access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  // Gain registers; writes to unmapped indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:  prop_gain_r  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_r <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended to the bus width.
  always_comb begin
    unique case (cfg_idx)
      REG_PROP_GAIN:  prdata = DATA_W'(prop_gain_r);
      REG_INTEG_GAIN: prdata = DATA_W'(integ_gain_r);
      REG_DERIV_GAIN: prdata = DATA_W'(deriv_gain_r);
      default:        prdata = '0;
    endcase
  end

  // Sequencer: steps the datapath through integral, divide and products.
  ipid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic, kept state and the result register.
  ipid_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_error_in        (in_error_in),
    .in_time_step       (in_time_step),
    .prop_gain          (prop_gain_r),
    .integ_gain         (integ_gain_r),
    .deriv_gain         (deriv_gain_r),
    .out_drive_out      (out_drive_out),
    .out_step_zero_flag (out_step_zero_flag),
    .out_valid          (out_valid),
    .out_ready          (out_ready)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in progress");

  a_cfg_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en |-> !cmd.load)
    else $error("load issued while accumulating");

  a_ready_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (in_valid && in_ready))
    else $error("datapath load without an accepted item");

endmodule
